@@ src/lcs_pkg.sv @@
// shared types and codes for the lcs traceback unit
package lcs_pkg;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_APPEND_A = 2'd0;
    localparam mode_t MODE_APPEND_B = 2'd1;
    localparam mode_t MODE_COMPUTE  = 2'd2;

    typedef struct packed
    {
        mode_t      mode;
        logic [7:0] symbol;
    } lcs_item_t;

    typedef struct packed
    {
        logic [7:0] out_symbol;
        logic [5:0] lcs_length;
        logic       is_last;
        logic       is_empty;
        logic       overflow;
    } lcs_result_t;

    typedef struct packed
    {
        logic match;
        logic take_up;
    } lcs_cell_flags_t;

endpackage

@@ src/lcs_in_if.sv @@
// input channel carrying mode and symbol
interface lcs_in_if;
    import lcs_pkg::*;

    logic      valid;
    logic      ready;
    lcs_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/lcs_out_if.sv @@
// output channel carrying subsequence results
interface lcs_out_if;
    import lcs_pkg::*;

    logic        valid;
    logic        ready;
    lcs_result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/lcs_with_backtrace_unit.sv @@
// lcs unit: string stores, packed length table, traceback and result emission
// appends are taken while idle; a compute fills the table, then walks the traceback (at most
// n+m steps) and emits the results, each paced by the single table read port pair and the
// registered memory reads; one item is worked on at a time
// reset clears lengths, overflow flag and control; memories hold no reset and need no
// clearing pass, since every entry is written before it is read
module lcs_with_backtrace_unit #(
    parameter int MAX_LEN = 32
) (
    input logic  clk,
    input logic  rst_n,
    lcs_in_if.sink    items,
    lcs_out_if.source results
);
    import lcs_pkg::*;

    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int SW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int DEPTH = MAX_LEN * MAX_LEN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [LW-1:0] ONE = LW'(1);

    typedef enum logic [6:0]
    {
        ST_IDLE    = 7'b0000001,
        ST_FILL_RD = 7'b0000010,
        ST_FILL_WR = 7'b0000100,
        ST_TB_RD   = 7'b0001000,
        ST_TB_DEC  = 7'b0010000,
        ST_EMIT_RD = 7'b0100000,
        ST_EMIT_LD = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [LW-1:0] length_a_reg, length_a_next;
    logic [LW-1:0] length_b_reg, length_b_next;
    logic          overflow_reg, overflow_next;
    logic [LW-1:0] n_reg, n_next;
    logic [LW-1:0] m_reg, m_next;
    logic          ovf_run_reg, ovf_run_next;
    logic [LW-1:0] i_reg, i_next;
    logic [LW-1:0] j_reg, j_next;
    logic [LW-1:0] k_reg, k_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [AW-1:0] w_reg, w_next;
    logic [AW-1:0] p_reg, p_next;
    logic [LW-1:0] left_reg, left_next;
    logic [LW-1:0] diag_reg, diag_next;
    logic          out_valid_reg, out_valid_next;
    lcs_result_t   out_data_reg, out_data_next;

    // memories
    logic [7:0]    a_mem [MAX_LEN];
    logic [7:0]    b_mem [MAX_LEN];
    logic [LW-1:0] dp_mem [DEPTH];
    logic [7:0]    tb_mem [MAX_LEN];

    logic [7:0]    a_q;
    logic [7:0]    b_q;
    logic [LW-1:0] up_q;
    logic [LW-1:0] left_q;
    logic [7:0]    tb_q;

    logic [SW-1:0] a_raddr;
    logic [SW-1:0] b_raddr;
    logic [AW-1:0] dp_raddr0;
    logic [AW-1:0] dp_raddr1;
    logic [SW-1:0] tb_raddr;

    logic          in_xfer;
    logic          out_xfer;
    logic          a_we;
    logic          b_we;
    logic          dp_we;
    logic          tb_we;

    logic [LW-1:0]   up_in;
    logic [LW-1:0]   left_in;
    logic [LW-1:0]   diag_in;
    logic [LW-1:0]   cell_value;
    lcs_cell_flags_t cell_flags;

    logic          empty_run;
    logic          last_result;
    logic [LW-1:0] ni;
    logic [LW-1:0] nj;
    logic [LW-1:0] nk;

    assign items.ready   = (state_reg == ST_IDLE);
    assign in_xfer       = items.valid && items.ready;
    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;
    assign out_xfer      = out_valid_reg && results.ready;

    assign a_we = in_xfer && (items.data.mode == MODE_APPEND_A)
                  && (length_a_reg < LW'(MAX_LEN));
    assign b_we = in_xfer && (items.data.mode == MODE_APPEND_B)
                  && (length_b_reg < LW'(MAX_LEN));
    assign dp_we = (state_reg == ST_FILL_WR);
    assign tb_we = (state_reg == ST_TB_DEC) && cell_flags.match;

    assign a_raddr   = SW'(i_reg - ONE);
    assign b_raddr   = SW'(j_reg - ONE);
    // cells packed row-major with stride m: up is one row back, left one cell back
    assign dp_raddr0 = ((state_reg == ST_FILL_RD) ? w_reg : p_reg) - AW'(m_reg);
    assign dp_raddr1 = p_reg - AW'(1);
    assign tb_raddr  = SW'(idx_reg);

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[SW'(length_a_reg)] <= items.data.symbol;
        end
        a_q <= a_mem[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[SW'(length_b_reg)] <= items.data.symbol;
        end
        b_q <= b_mem[b_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dp_we)
        begin
            dp_mem[w_reg] <= cell_value;
        end
        up_q   <= dp_mem[dp_raddr0];
        left_q <= dp_mem[dp_raddr1];
    end

    always_ff @(posedge clk)
    begin
        if (tb_we)
        begin
            tb_mem[SW'(k_reg - ONE)] <= a_q;
        end
        tb_q <= tb_mem[tb_raddr];
    end

    // row zero and column zero of the table read as zero
    assign up_in   = (i_reg == ONE) ? '0 : up_q;
    assign left_in = (j_reg == ONE) ? '0 : ((state_reg == ST_TB_DEC) ? left_q : left_reg);
    assign diag_in = ((i_reg == ONE) || (j_reg == ONE)) ? '0 : diag_reg;

    lcs_cell #(
        .W (LW)
    ) u_cell (
        .a_sym (a_q),
        .b_sym (b_q),
        .up    (up_in),
        .left  (left_in),
        .diag  (diag_in),
        .flags (cell_flags),
        .value (cell_value)
    );

    assign empty_run   = (len_reg == '0);
    assign last_result = empty_run || (idx_reg == (len_reg - ONE));

    always_comb
    begin
        ni = i_reg;
        nj = j_reg;
        nk = k_reg;
        if (cell_flags.match)
        begin
            ni = i_reg - ONE;
            nj = j_reg - ONE;
            nk = k_reg - ONE;
        end
        else if (cell_flags.take_up)
        begin
            ni = i_reg - ONE;
        end
        else
        begin
            nj = j_reg - ONE;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        length_a_next  = length_a_reg;
        length_b_next  = length_b_reg;
        overflow_next  = overflow_reg;
        n_next         = n_reg;
        m_next         = m_reg;
        ovf_run_next   = ovf_run_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        w_next         = w_reg;
        p_next         = p_reg;
        left_next      = left_reg;
        diag_next      = diag_reg;
        out_valid_next = out_xfer ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (items.data.mode)
                        MODE_APPEND_A:
                        begin
                            if (a_we)
                            begin
                                length_a_next = length_a_reg + ONE;
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        MODE_APPEND_B:
                        begin
                            if (b_we)
                            begin
                                length_b_next = length_b_reg + ONE;
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        MODE_COMPUTE:
                        begin
                            n_next        = length_a_reg;
                            m_next        = length_b_reg;
                            ovf_run_next  = overflow_reg;
                            length_a_next = '0;
                            length_b_next = '0;
                            overflow_next = 1'b0;
                            i_next        = ONE;
                            j_next        = ONE;
                            w_next        = '0;
                            idx_next      = '0;
                            if ((length_a_reg == '0) || (length_b_reg == '0))
                            begin
                                len_next   = '0;
                                state_next = ST_EMIT_RD;
                            end
                            else
                            begin
                                state_next = ST_FILL_RD;
                            end
                        end
                        default:
                        begin
                            // unused mode is dropped
                        end
                    endcase
                end
            end
            ST_FILL_RD:
            begin
                state_next = ST_FILL_WR;
            end
            ST_FILL_WR:
            begin
                w_next    = w_reg + AW'(1);
                left_next = cell_value;
                diag_next = up_in;
                if (j_reg == m_reg)
                begin
                    if (i_reg == n_reg)
                    begin
                        // corner reached: start traceback from the last cell written
                        len_next = cell_value;
                        k_next   = cell_value;
                        p_next   = w_reg;
                        idx_next = '0;
                        state_next = (cell_value == '0) ? ST_EMIT_RD : ST_TB_RD;
                    end
                    else
                    begin
                        j_next     = ONE;
                        i_next     = i_reg + ONE;
                        state_next = ST_FILL_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + ONE;
                    state_next = ST_FILL_RD;
                end
            end
            ST_TB_RD:
            begin
                state_next = ST_TB_DEC;
            end
            ST_TB_DEC:
            begin
                i_next = ni;
                j_next = nj;
                k_next = nk;
                if (cell_flags.match)
                begin
                    p_next = p_reg - AW'(m_reg) - AW'(1);
                end
                else if (cell_flags.take_up)
                begin
                    p_next = p_reg - AW'(m_reg);
                end
                else
                begin
                    p_next = p_reg - AW'(1);
                end
                if ((ni != '0) && (nj != '0) && (nk != '0))
                begin
                    state_next = ST_TB_RD;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                // advance only once the output register is free at this edge; buffer read issues now
                if (!out_valid_reg || results.ready)
                begin
                    state_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD:
            begin
                out_valid_next           = 1'b1;
                out_data_next.out_symbol = empty_run ? 8'd0 : tb_q;
                out_data_next.lcs_length = 6'(len_reg);
                out_data_next.is_last    = last_result;
                out_data_next.is_empty   = empty_run;
                out_data_next.overflow   = ovf_run_reg;
                if (last_result)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + ONE;
                    state_next = ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            length_a_reg  <= '0;
            length_b_reg  <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            length_a_reg  <= length_a_next;
            length_b_reg  <= length_b_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        m_reg        <= m_next;
        ovf_run_reg  <= ovf_run_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        len_reg      <= len_next;
        idx_reg      <= idx_next;
        w_reg        <= w_next;
        p_reg        <= p_next;
        left_reg     <= left_next;
        diag_reg     <= diag_next;
        out_data_reg <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    a_fill_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL_WR) |-> ((i_reg != '0) && (j_reg != '0)
            && (i_reg <= n_reg) && (j_reg <= m_reg)))
        else $error("fill indices out of range");

    a_tb_invariant: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TB_DEC) |-> ((k_reg != '0) && (k_reg <= i_reg) && (k_reg <= j_reg)))
        else $error("traceback count exceeds remaining prefix");

    a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT_LD) && !empty_run) |-> (idx_reg < len_reg))
        else $error("emit index past subsequence length");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT_LD))
        else $error("result valid raised outside emit load");
`endif

endmodule

@@ src/lcs_cell.sv @@
// lcs recurrence cell: match test, tie rule and new table value
module lcs_cell #(
    parameter int W = 6
) (
    input  logic [7:0]              a_sym,
    input  logic [7:0]              b_sym,
    input  logic [W-1:0]            up,
    input  logic [W-1:0]            left,
    input  logic [W-1:0]            diag,
    output lcs_pkg::lcs_cell_flags_t flags,
    output logic [W-1:0]            value
);
    import lcs_pkg::*;

    always_comb
    begin
        flags.match   = (a_sym == b_sym);
        // upper cell wins ties
        flags.take_up = (up >= left);
        if (flags.match)
        begin
            value = diag + W'(1);
        end
        else if (flags.take_up)
        begin
            value = up;
        end
        else
        begin
            value = left;
        end
    end
endmodule

@@ dv/lcs_traceback_checker.sv @@
// checker for the lcs unit: tracks both channels, predicts subsequence results and compares
`timescale 1ns / 100ps

module lcs_traceback_checker #(
    parameter int MAX_LEN = 32
) (
    input logic  clk,
    input logic  rst_n,
    lcs_in_if    items,
    lcs_out_if   results,
    output int   mismatches,
    output int   outstanding
);
    import lcs_pkg::*;

    logic [7:0]  str_a [MAX_LEN];
    logic [7:0]  str_b [MAX_LEN];
    int          len_a;
    int          len_b;
    bit          dropped;
    int          fail_count = 0;
    lcs_result_t subseq_q[$];

    assign mismatches = fail_count;

    // fills the length table, walks back from the corner and queues the subsequence
    function automatic void run_lcs();
        int          dp [0:MAX_LEN][0:MAX_LEN];
        logic [7:0]  common [MAX_LEN];
        int          i;
        int          j;
        int          k;
        int          total;
        lcs_result_t r;

        for (i = 0; i <= len_a; i++)
            dp[i][0] = 0;
        for (j = 0; j <= len_b; j++)
            dp[0][j] = 0;
        for (i = 1; i <= len_a; i++)
        begin
            for (j = 1; j <= len_b; j++)
            begin
                if (str_a[i-1] == str_b[j-1])
                    dp[i][j] = dp[i-1][j-1] + 1;
                else if (dp[i-1][j] >= dp[i][j-1])
                    dp[i][j] = dp[i-1][j];
                else
                    dp[i][j] = dp[i][j-1];
            end
        end

        total = dp[len_a][len_b];
        k = total;
        i = len_a;
        j = len_b;
        while (i > 0 && j > 0 && k > 0)
        begin
            if (str_a[i-1] == str_b[j-1])
            begin
                k--;
                common[k] = str_a[i-1];
                i--;
                j--;
            end
            else if (dp[i-1][j] >= dp[i][j-1])
                i--;
            else
                j--;
        end

        if (total == 0)
        begin
            r.out_symbol = 8'd0;
            r.lcs_length = 6'd0;
            r.is_last    = 1'b1;
            r.is_empty   = 1'b1;
            r.overflow   = dropped;
            subseq_q = {subseq_q, r};
        end
        else
        begin
            for (k = 0; k < total; k++)
            begin
                r.out_symbol = common[k];
                r.lcs_length = 6'(total);
                r.is_last    = (k + 1 == total);
                r.is_empty   = 1'b0;
                r.overflow   = dropped;
                subseq_q = {subseq_q, r};
            end
        end

        len_a   = 0;
        len_b   = 0;
        dropped = 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        lcs_result_t got;
        lcs_result_t want;

        if (!rst_n)
        begin
            len_a   = 0;
            len_b   = 0;
            dropped = 1'b0;
            subseq_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                got = results.data;
                if (subseq_q.size() == 0)
                begin
                    $error("unexpected result: out_symbol %0d lcs_length %0d is_last %0d",
                           got.out_symbol, got.lcs_length, got.is_last);
                    fail_count++;
                end
                else
                begin
                    want = subseq_q.pop_front();
                    if (got.out_symbol !== want.out_symbol)
                    begin
                        $error("out_symbol: expected %0d, actual %0d",
                               want.out_symbol, got.out_symbol);
                        fail_count++;
                    end
                    if (got.lcs_length !== want.lcs_length)
                    begin
                        $error("lcs_length: expected %0d, actual %0d",
                               want.lcs_length, got.lcs_length);
                        fail_count++;
                    end
                    if (got.is_last !== want.is_last)
                    begin
                        $error("is_last: expected %0d, actual %0d", want.is_last, got.is_last);
                        fail_count++;
                    end
                    if (got.is_empty !== want.is_empty)
                    begin
                        $error("is_empty: expected %0d, actual %0d",
                               want.is_empty, got.is_empty);
                        fail_count++;
                    end
                    if (got.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0d, actual %0d",
                               want.overflow, got.overflow);
                        fail_count++;
                    end
                end
            end

            if (items.valid && items.ready)
            begin
                case (items.data.mode)
                    MODE_APPEND_A:
                    begin
                        if (len_a >= MAX_LEN)
                            dropped = 1'b1;
                        else
                        begin
                            str_a[len_a] = items.data.symbol;
                            len_a++;
                        end
                    end
                    MODE_APPEND_B:
                    begin
                        if (len_b >= MAX_LEN)
                            dropped = 1'b1;
                        else
                        begin
                            str_b[len_b] = items.data.symbol;
                            len_b++;
                        end
                    end
                    MODE_COMPUTE:
                        run_lcs();
                    default:
                        ; // unused mode code leaves everything alone
                endcase
            end

            outstanding <= subseq_q.size();
        end
    end

endmodule

@@ dv/lcs_with_backtrace_unit_test.sv @@
// testbench top for the lcs unit: clock, reset, stimulus, output stalls and verdict
`timescale 1ns / 100ps

module lcs_with_backtrace_unit_test;
    import lcs_pkg::*;

    localparam int    STR_MAX      = 32;
    localparam int    RANDOM_ITEMS = 310;
    localparam int    CYCLE_LIMIT  = 600000;
    localparam int    TAIL_CYCLES  = 40;
    localparam mode_t MODE_UNUSED  = 2'd3;

    logic clk;
    logic rst_n;
    int   cycles = 0;
    int   mismatches;
    int   outstanding;
    int   counted = 0;
    bit   no_gaps = 1'b0;

    lcs_in_if  items_ch ();
    lcs_out_if results_ch ();

    lcs_with_backtrace_unit #(
        .MAX_LEN (STR_MAX)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch)
    );

    lcs_traceback_checker #(
        .MAX_LEN (STR_MAX)
    ) chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .items       (items_ch),
        .results     (results_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // random idle between transfers on the input side
    task automatic pause();
        int r;
        int gap;

        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            gap = 0;
        else if (r < 93)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            items_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send(mode_t m, logic [7:0] s);
        items_ch.valid <= 1'b1;
        items_ch.data  <= '{mode: m, symbol: s};
        do @(posedge clk); while (!items_ch.ready);
        if (m != MODE_UNUSED)
            counted++;
        pause();
    endtask

    // hold the input until every queued result has come out
    task automatic drain();
        items_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    function automatic logic [7:0] pick_sym(logic [7:0] base, int spread);
        return base ^ 8'($urandom_range(0, spread));
    endfunction

    // loads two strings in random interleaving with occasional unused-mode items, then computes
    task automatic run_pair(int na, int nb, logic [7:0] base, int spread);
        int a_left;
        int b_left;

        a_left = na;
        b_left = nb;
        while (a_left + b_left > 0)
        begin
            if (b_left == 0 || (a_left > 0 && $urandom_range(0, 1) == 1))
            begin
                send(MODE_APPEND_A, pick_sym(base, spread));
                a_left--;
            end
            else
            begin
                send(MODE_APPEND_B, pick_sym(base, spread));
                b_left--;
            end
            if ($urandom_range(0, 15) == 0)
                send(MODE_UNUSED, 8'($urandom_range(0, 255)));
        end
        send(MODE_COMPUTE, 8'($urandom_range(0, 255)));
    endtask

    function automatic int pick_spread();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 1;
            2: return 3;
            default: return 255;
        endcase
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(9, 20);
        return $urandom_range(1, 8);
    endfunction

    initial
    begin : output_stalls
        int r;
        int run;
        int stall;

        results_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                run = $urandom_range(1, 3);
            else if (r < 90)
                run = $urandom_range(4, 20);
            else
                run = $urandom_range(50, 200);
            results_ch.ready <= 1'b1;
            repeat (run) @(posedge clk);
            r = $urandom_range(0, 99);
            if (r < 60)
                stall = $urandom_range(1, 2);
            else if (r < 95)
                stall = $urandom_range(3, 8);
            else
                stall = $urandom_range(20, 40);
            results_ch.ready <= 1'b0;
            repeat (stall) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int  r;
        bit  first;
        int  i;

        items_ch.valid <= 1'b0;
        items_ch.data  <= '0;
        rst_n          <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // both strings empty
        send(MODE_COMPUTE, 8'h00);
        // extreme bytes in crossed order: up and left tie, traceback must go up
        send(MODE_APPEND_A, 8'h00);
        send(MODE_APPEND_A, 8'hff);
        send(MODE_UNUSED, 8'hff);
        send(MODE_APPEND_B, 8'hff);
        send(MODE_APPEND_B, 8'h00);
        send(MODE_COMPUTE, 8'hff);
        // one side empty
        send(MODE_APPEND_A, 8'h41);
        send(MODE_COMPUTE, 8'h00);
        send(MODE_APPEND_B, 8'h55);
        send(MODE_APPEND_B, 8'haa);
        send(MODE_UNUSED, 8'h00);
        send(MODE_COMPUTE, 8'h00);
        // identical strings
        for (i = 1; i <= 3; i++)
            send(MODE_APPEND_A, 8'(i));
        for (i = 1; i <= 3; i++)
            send(MODE_APPEND_B, 8'(i));
        send(MODE_COMPUTE, 8'h00);

        counted = 0;
        first = 1'b1;
        while (counted < RANDOM_ITEMS)
        begin
            no_gaps = ($urandom_range(0, 5) == 0);
            r = $urandom_range(0, 99);
            if (first || r < 6)
            begin
                // full strings, first one overruns so the drop flag is seen
                run_pair(STR_MAX + (first ? 2 : $urandom_range(0, 3)),
                         STR_MAX + $urandom_range(0, 2),
                         8'($urandom_range(0, 255)), first ? 1 : pick_spread());
            end
            else if (r < 14)
            begin
                if ($urandom_range(0, 1) == 1)
                    run_pair(0, pick_len(), 8'($urandom_range(0, 255)), pick_spread());
                else
                    run_pair(pick_len(), 0, 8'($urandom_range(0, 255)), pick_spread());
            end
            else if (r < 22)
            begin
                repeat ($urandom_range(1, 6))
                    send(mode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
            else
            begin
                run_pair(pick_len(), pick_len(), 8'($urandom_range(0, 255)), pick_spread());
            end
            if (first || $urandom_range(0, 7) == 0)
                drain();
            first = 1'b0;
        end

        items_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
